/* sv/nvrd_pkg.sv */
// nvrd_pkg: shared types and constants for the named value record decoder
// holds channel payload types, the command passed from front to back, and the parser phases
// no dependencies
package nvrd_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned VALUE_W     = 64;
	localparam int unsigned NAME_W      = 31;
	localparam int unsigned NAME_OUT_W  = 16;
	localparam int unsigned QUEUE_DEPTH = 4;

	// header word layout
	localparam int unsigned DEFINE_BIT = 31;

	// input request payload
	typedef struct packed {
		logic [WORD_W-1:0] word;
	} in_item_t;

	// output request payload
	typedef struct packed {
		logic [VALUE_W-1:0]    value;
		logic [NAME_OUT_W-1:0] name;
		logic                  defined_now;
		logic                  name_error;
	} out_item_t;

	// per-record control fields passed through the queue
	typedef struct packed {
		logic                  defined_now;
		logic                  name_error;
		logic [NAME_OUT_W-1:0] name;
	} cmd_meta_t;

	// word parser phases
	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_LOW    = 3'b010,
		PH_HIGH   = 3'b100
	} phase_t;

endpackage

/* sv/nvrd_if.sv */
// nvrd_if: valid/ready channel carrying one payload of type T
// no dependencies
interface nvrd_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* sv/named_value_record_decoder.sv */
// named_value_record_decoder: one wire word accepted per cycle while the queue has room and the sweep is done
// after its last word is accepted, a record's command is written to the queue and then loaded into the output register
// the name table is read or written at most once per record
// after reset the table is cleared one entry per cycle, all NAME_COUNT entries, with input not ready
// reset returns the parser to expect a header and empties the queue and output register
// depends on nvrd_pkg, nvrd_if, nvrd_front, nvrd_fifo, nvrd_back
module named_value_record_decoder #(
	parameter int unsigned NAME_COUNT = 65536
) (
	input  logic  clk,
	input  logic  arst_n,
	nvrd_if.sink   words,
	nvrd_if.source records
);
	import nvrd_pkg::*;

	localparam int unsigned AW = (NAME_COUNT > 1) ? $clog2(NAME_COUNT) : 1;

	logic               push;
	cmd_meta_t          push_meta;
	logic [AW-1:0]      push_idx;
	logic [VALUE_W-1:0] push_value;
	logic               fifo_full;
	logic               fifo_empty;
	logic               pop;
	cmd_meta_t          head_meta;
	logic [AW-1:0]      head_idx;
	logic [VALUE_W-1:0] head_value;
	logic               clear_busy;

	// word parser
	nvrd_front #(.NAME_COUNT(NAME_COUNT), .AW(AW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.words      (words),
		.clear_busy (clear_busy),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_meta  (push_meta),
		.push_idx   (push_idx),
		.push_value (push_value)
	);

	// command queue
	nvrd_fifo #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_meta  (push_meta),
		.push_idx   (push_idx),
		.push_value (push_value),
		.full       (fifo_full),
		.pop        (pop),
		.empty      (fifo_empty),
		.head_meta  (head_meta),
		.head_idx   (head_idx),
		.head_value (head_value)
	);

	// table and output
	nvrd_back #(.NAME_COUNT(NAME_COUNT), .AW(AW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (fifo_empty),
		.head_meta  (head_meta),
		.head_idx   (head_idx),
		.head_value (head_value),
		.pop        (pop),
		.clear_busy (clear_busy),
		.records    (records)
	);

endmodule

/* sv/nvrd_front.sv */
// nvrd_front: accepts wire words, tracks record phase, emits one command per record
// depends on nvrd_pkg and nvrd_if
module nvrd_front #(
	parameter int unsigned NAME_COUNT = 65536,
	parameter int unsigned AW         = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	nvrd_if.sink                           words,
	input  logic                           clear_busy,
	input  logic                           fifo_full,
	output logic                           push,
	output nvrd_pkg::cmd_meta_t            push_meta,
	output logic [AW-1:0]                  push_idx,
	output logic [nvrd_pkg::VALUE_W-1:0]   push_value
);
	import nvrd_pkg::*;

	phase_t                phase_q;
	logic [NAME_OUT_W-1:0] pend_name_q;
	logic [AW-1:0]         pend_idx_q;
	logic                  pend_bad_q;
	logic [WORD_W-1:0]     low_half_q;

	logic              acc;
	logic [WORD_W-1:0] w;
	logic [NAME_W-1:0] nm;
	logic              bad;
	logic              is_def;

	// input handshake and header decode
	assign words.ready = !clear_busy && !fifo_full;
	assign acc         = words.valid && words.ready;
	assign w           = words.data.word;
	assign nm          = w[NAME_W-1:0];
	assign bad         = !(nm < NAME_W'(NAME_COUNT));
	assign is_def      = w[DEFINE_BIT];

	// command build
	always_comb begin
		push       = 1'b0;
		push_meta  = '0;
		push_idx   = nm[AW-1:0];
		push_value = '0;
		unique case (phase_q)
			PH_LOW: begin
				push = 1'b0;
			end
			PH_HIGH: begin
				push       = acc;
				push_meta  = '{defined_now: 1'b1, name_error: pend_bad_q, name: pend_name_q};
				push_idx   = pend_idx_q;
				push_value = {w, low_half_q};
			end
			default: begin
				push      = acc && !is_def;
				push_meta = '{defined_now: 1'b0, name_error: bad, name: nm[NAME_OUT_W-1:0]};
			end
		endcase
	end

	// phase tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
		end else if (acc) begin
			unique case (phase_q)
				PH_LOW:  phase_q <= PH_HIGH;
				PH_HIGH: phase_q <= PH_HEADER;
				default: phase_q <= is_def ? PH_LOW : PH_HEADER;
			endcase
		end
	end

	// pending record fields
	always_ff @(posedge clk) begin
		if (acc && phase_q == PH_HEADER && is_def) begin
			pend_name_q <= nm[NAME_OUT_W-1:0];
			pend_idx_q  <= nm[AW-1:0];
			pend_bad_q  <= bad;
		end
		if (acc && phase_q == PH_LOW) begin
			low_half_q <= w;
		end
	end

endmodule

/* sv/nvrd_fifo.sv */
// nvrd_fifo: short command queue between the front and back parts
// depends on nvrd_pkg; DEPTH must be a power of two
module nvrd_fifo #(
	parameter int unsigned DEPTH = 4,
	parameter int unsigned AW    = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  nvrd_pkg::cmd_meta_t          push_meta,
	input  logic [AW-1:0]                push_idx,
	input  logic [nvrd_pkg::VALUE_W-1:0] push_value,
	output logic                         full,
	input  logic                         pop,
	output logic                         empty,
	output nvrd_pkg::cmd_meta_t          head_meta,
	output logic [AW-1:0]                head_idx,
	output logic [nvrd_pkg::VALUE_W-1:0] head_value
);
	import nvrd_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cmd_meta_t          meta_q  [DEPTH];
	logic [AW-1:0]      idx_q   [DEPTH];
	logic [VALUE_W-1:0] value_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [PW:0]        count_q;

	logic do_push;
	logic do_pop;

	assign full    = count_q == (PW+1)'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	assign head_meta  = meta_q[rd_ptr_q];
	assign head_idx   = idx_q[rd_ptr_q];
	assign head_value = value_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (!do_push && do_pop) count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			meta_q[wr_ptr_q]  <= push_meta;
			idx_q[wr_ptr_q]   <= push_idx;
			value_q[wr_ptr_q] <= push_value;
		end
	end

endmodule

/* sv/nvrd_back.sv */
// nvrd_back: name table access, reset clearing sweep and output register
// depends on nvrd_pkg and nvrd_if
module nvrd_back #(
	parameter int unsigned NAME_COUNT = 65536,
	parameter int unsigned AW         = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         empty,
	input  nvrd_pkg::cmd_meta_t          head_meta,
	input  logic [AW-1:0]                head_idx,
	input  logic [nvrd_pkg::VALUE_W-1:0] head_value,
	output logic                         pop,
	output logic                         clear_busy,
	nvrd_if.source                       records
);
	import nvrd_pkg::*;

	logic [VALUE_W-1:0] mem [NAME_COUNT];
	logic [VALUE_W-1:0] rdata_q;

	logic               clr_busy_q;
	logic [AW-1:0]      clr_addr_q;

	logic               vld_s2;
	cmd_meta_t          meta_s2;
	logic [VALUE_W-1:0] val_s2;
	logic               use_mem_s2;

	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [VALUE_W-1:0] mem_wd;
	logic               rd_en;
	logic               head_ok;

	// issue one command when the queue is not empty, the sweep is done and the output slot is free or draining
	assign clear_busy = clr_busy_q;
	assign pop        = !clr_busy_q && !empty && (!vld_s2 || records.ready);
	assign head_ok    = !head_meta.name_error;
	assign rd_en      = pop && !head_meta.defined_now && head_ok;

	// table write port: clearing sweep or definition
	always_comb begin
		mem_we = clr_busy_q || (pop && head_meta.defined_now && head_ok);
		mem_wa = clr_busy_q ? clr_addr_q : head_idx;
		mem_wd = clr_busy_q ? '0 : head_value;
	end

	// name table
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (rd_en)  rdata_q <= mem[head_idx];
	end

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(NAME_COUNT - 1)) clr_busy_q <= 1'b0;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (pop) begin
			vld_s2 <= 1'b1;
		end else if (records.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			meta_s2    <= head_meta;
			val_s2     <= head_value;
			use_mem_s2 <= !head_meta.defined_now && head_ok;
		end
	end

	// result drive
	always_comb begin
		records.valid            = vld_s2;
		records.data.value       = meta_s2.name_error ? '0 : (use_mem_s2 ? rdata_q : val_s2);
		records.data.name        = meta_s2.name;
		records.data.defined_now = meta_s2.defined_now;
		records.data.name_error  = meta_s2.name_error;
	end

endmodule
